// ===== hw/rtl/nlmsp_pkg.sv =====
package nlmsp_pkg;

   // Field and arithmetic widths fixed by the sample, weight and step formats.
   localparam int SAMPLE_W = 16;
   localparam int WEIGHT_W = 32;
   localparam int STEP_W   = 16;
   localparam int ERR_W    = 17;
   localparam int QUOT_W   = 34;
   localparam int NUM_W    = 60;
   localparam int ORDER_DEF = 8;
   localparam int STEP_RESET = 8192;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRED,
      ST_FLUSH,
      ST_EVAL,
      ST_MU,
      ST_TMUL,
      ST_TSTART,
      ST_TDIV,
      ST_TWR,
      ST_SHIFT,
      ST_OUT
   } state_type;

   // What every cell of the row does in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_SHIFT
   } cell_mode_type;

   // Reset weight of a tap: 2.0, -1.0 and zero, or a single 1.0 for a one-tap row.
   function automatic logic signed [WEIGHT_W-1:0] init_weight(input int order, input int idx);
      logic signed [WEIGHT_W-1:0] w;
      w = '0;
      if (order == 1) begin
         w = WEIGHT_W'(32'sh0100_0000);
      end else if (idx == 0) begin
         w = WEIGHT_W'(32'sh0200_0000);
      end else if (idx == 1) begin
         w = WEIGHT_W'(-32'sh0100_0000);
      end
      return w;
   endfunction

endpackage

// ===== hw/rtl/nlmsp_cell.sv =====
module nlmsp_cell #(
   parameter logic signed [nlmsp_pkg::WEIGHT_W-1:0] INIT_W = '0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  nlmsp_pkg::cell_mode_type                  mode,
   input  logic signed [nlmsp_pkg::WEIGHT_W-1:0]     feed_w,
   input  logic signed [nlmsp_pkg::SAMPLE_W-1:0]     feed_h,
   input  logic signed [nlmsp_pkg::SAMPLE_W-1:0]     prev_h,
   output logic signed [nlmsp_pkg::WEIGHT_W-1:0]     w_out,
   output logic signed [nlmsp_pkg::SAMPLE_W-1:0]     h_out
);

   logic signed [nlmsp_pkg::WEIGHT_W-1:0] w_ff, w_in;
   logic signed [nlmsp_pkg::SAMPLE_W-1:0] h_ff, h_in;

   // A rotation moves the weight and sample pair one cell towards the head;
   // a shift moves only the samples one cell away from it.
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      case (mode)
         nlmsp_pkg::CELL_ROTATE: begin
            w_in = feed_w;
            h_in = feed_h;
         end
         nlmsp_pkg::CELL_SHIFT: begin
            h_in = prev_h;
         end
         default: begin
            w_in = w_ff;
            h_in = h_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= INIT_W;
      end else begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
   end

   assign w_out = w_ff;
   assign h_out = h_ff;

endmodule

// ===== hw/rtl/nlmsp_div.sv =====
module nlmsp_div #(
   parameter int DEN_W = 34
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [nlmsp_pkg::NUM_W-1:0]         numer,
   input  logic [DEN_W-1:0]                    denom,
   output logic                                done,
   output logic [nlmsp_pkg::QUOT_W-1:0]        quot
);

   localparam int QW    = nlmsp_pkg::QUOT_W;
   localparam int CMP_W = DEN_W + nlmsp_pkg::NUM_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [QW-1:0]    q_ff, q_in;
   logic             ovf;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   // The high part of the numerator at or above the divisor means the quotient
   // does not fit; it is then pinned to all ones, which still saturates the tap.
   assign ovf = CMP_W'(numer[nlmsp_pkg::NUM_W-1:QW]) >= CMP_W'(denom);

   // One restoring step a cycle.
   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      if (start) begin
         den_in = denom;
         cnt_in = '0;
         if (ovf) begin
            q_in    = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = DEN_W'(numer[nlmsp_pkg::NUM_W-1:QW]);
            low_in  = numer[QW-1:0];
            q_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         low_in = {low_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ===== hw/rtl/nlmsp_adaptive_predictor.sv =====
// Each sample is shifted into the history; the one that fills it also gets a next prediction.
// Once the history is full, a sample first gets a prediction and its error, then each tap is
// updated in turn through the serial divider before the shift and the next prediction. The
// result is offered in the same cycle in which the next transfer can be taken; a result
// waiting in the output register stalls only the sample after the next one.
// Reset (synchronous, active high) loads the weights 2.0, -1.0, 0... (1.0 for one tap),
// empties the history count and sets the step size to 0.5.
module nlms_adaptive_predictor #(
   parameter int ORDER = nlmsp_pkg::ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [16:0] error, [32:17] next_prediction, rest zero
   output logic        rsp_tuser,   // [0] ready_res
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // [15:0] step_size
);

   localparam int SW    = nlmsp_pkg::SAMPLE_W;
   localparam int WW    = nlmsp_pkg::WEIGHT_W;
   localparam int EW_E  = nlmsp_pkg::ERR_W;
   localparam int QW    = nlmsp_pkg::QUOT_W;
   localparam int NW    = nlmsp_pkg::NUM_W;
   localparam int PW    = WW + SW;
   localparam int AW    = PW + $clog2(ORDER);
   localparam int EW    = 31 + $clog2(ORDER);
   localparam int CW    = $clog2(ORDER + 1);
   localparam int MW    = nlmsp_pkg::STEP_W + EW_E;
   localparam int XW    = MW + SW;
   localparam int SUM_W = QW + 2;

   localparam logic signed [AW-1:0] P_MAX = AW'(32767);
   localparam logic signed [AW-1:0] P_MIN = AW'(-32768);
   localparam logic signed [AW-1:0] P_RND = AW'(1 << 23);

   nlmsp_pkg::state_type     state_ff, state_in;
   nlmsp_pkg::cell_mode_type mode;

   logic [nlmsp_pkg::STEP_W-1:0] step_ff, step_in;
   logic [CW-1:0]                loaded_ff, loaded_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         phase_ff, phase_in;
   logic signed [SW-1:0]         s_ff, s_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic [2*SW-1:0]              sq_ff, sq_in;
   logic                         pv_ff, pv_in;
   logic signed [AW-1:0]         acc_ff, acc_in;
   logic [EW-1:0]                en_ff, en_in;
   logic [EW-1:0]                den_ff, den_in;
   logic signed [EW_E-1:0]       err_ff, err_in;
   logic signed [SW-1:0]         np_ff, np_in;
   logic [MW-1:0]                mue_ff, mue_in;
   logic [XW-1:0]                num_ff, num_in;
   logic                         rv_ff, rv_in;
   logic [39:0]                  rd_ff, rd_in;
   logic                         ru_ff, ru_in;

   logic signed [WW-1:0] cw [ORDER];
   logic signed [SW-1:0] ch [ORDER];
   logic signed [WW-1:0] head_w_feed;

   logic                 div_start;
   logic [NW-1:0]        div_num;
   logic                 div_done;
   logic [QW-1:0]        div_q;

   logic signed [AW-1:0]   acc_r;
   logic signed [AW-1:0]   acc_sh;
   logic signed [SW-1:0]   pred_sat;
   logic [EW_E-1:0]        err_mag;
   logic [SW-1:0]          h_mag;
   logic                   neg;
   logic signed [SUM_W-1:0] w_sum;
   logic signed [WW-1:0]   w_new;
   logic [CW-1:0]          loaded_next;

   // Row of tap cells; cell 0 is the head that the shared arithmetic reads.
   for (genvar i = 0; i < ORDER; i++) begin : g_cell
      logic signed [WW-1:0] fw;
      logic signed [SW-1:0] fh;
      logic signed [SW-1:0] ph;
      if (i == ORDER - 1) begin : g_last
         assign fw = head_w_feed;
         assign fh = ch[0];
      end else begin : g_mid
         assign fw = cw[i + 1];
         assign fh = ch[i + 1];
      end
      if (i == 0) begin : g_first
         assign ph = s_ff;
      end else begin : g_rest
         assign ph = ch[i - 1];
      end
      nlmsp_cell #(
         .INIT_W (nlmsp_pkg::init_weight(ORDER, i))
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .mode   (mode),
         .feed_w (fw),
         .feed_h (fh),
         .prev_h (ph),
         .w_out  (cw[i]),
         .h_out  (ch[i])
      );
   end

   nlmsp_div #(
      .DEN_W (EW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (den_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // Rounding and saturation of the dot product to Q1.15.
   assign acc_r  = acc_ff + P_RND;
   assign acc_sh = acc_r >>> 24;
   always_comb begin
      if (acc_sh > P_MAX) begin
         pred_sat = SW'(16'sh7fff);
      end else if (acc_sh < P_MIN) begin
         pred_sat = SW'(-16'sh8000);
      end else begin
         pred_sat = acc_sh[SW-1:0];
      end
   end

   // Tap update arithmetic on the head cell.
   assign err_mag = err_ff[EW_E-1] ? EW_E'(-err_ff) : EW_E'(err_ff);
   assign h_mag   = ch[0][SW-1] ? SW'(-ch[0]) : SW'(ch[0]);
   assign neg     = err_ff[EW_E-1] ^ ch[0][SW-1];
   assign w_sum   = neg ? (SUM_W'(cw[0]) - $signed({2'b00, div_q}))
                        : (SUM_W'(cw[0]) + $signed({2'b00, div_q}));
   always_comb begin
      if (w_sum > SUM_W'(32'sh7fff_ffff)) begin
         w_new = WW'(32'sh7fff_ffff);
      end else if (w_sum < SUM_W'(-33'sh0_8000_0000)) begin
         w_new = WW'(-33'sh0_8000_0000);
      end else begin
         w_new = w_sum[WW-1:0];
      end
   end

   assign div_num     = NW'({num_ff, 10'b0}) + NW'(den_ff >> 1);
   assign loaded_next = (loaded_ff == CW'(ORDER)) ? loaded_ff : loaded_ff + CW'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nlmsp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (loaded_ff == CW'(ORDER)) ? nlmsp_pkg::ST_PRED : nlmsp_pkg::ST_SHIFT;
            end
         end
         nlmsp_pkg::ST_PRED: begin
            if (cnt_ff == CW'(ORDER - 1)) begin
               state_in = nlmsp_pkg::ST_FLUSH;
            end
         end
         nlmsp_pkg::ST_FLUSH:  state_in = nlmsp_pkg::ST_EVAL;
         nlmsp_pkg::ST_EVAL:   state_in = phase_ff ? nlmsp_pkg::ST_OUT : nlmsp_pkg::ST_MU;
         nlmsp_pkg::ST_MU:     state_in = nlmsp_pkg::ST_TMUL;
         nlmsp_pkg::ST_TMUL:   state_in = nlmsp_pkg::ST_TSTART;
         nlmsp_pkg::ST_TSTART: state_in = nlmsp_pkg::ST_TDIV;
         nlmsp_pkg::ST_TDIV: begin
            if (div_done) begin
               state_in = nlmsp_pkg::ST_TWR;
            end
         end
         nlmsp_pkg::ST_TWR: begin
            state_in = (cnt_ff == CW'(ORDER - 1)) ? nlmsp_pkg::ST_SHIFT : nlmsp_pkg::ST_TMUL;
         end
         nlmsp_pkg::ST_SHIFT: begin
            state_in = (loaded_next == CW'(ORDER)) ? nlmsp_pkg::ST_PRED : nlmsp_pkg::ST_OUT;
         end
         nlmsp_pkg::ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               state_in = nlmsp_pkg::ST_IDLE;
            end
         end
         default: state_in = nlmsp_pkg::ST_IDLE;
      endcase
   end

   // Datapath control and next register values.
   always_comb begin
      mode         = nlmsp_pkg::CELL_HOLD;
      head_w_feed  = cw[0];
      div_start    = 1'b0;
      step_in      = csr_we ? csr_wdata : step_ff;
      loaded_in    = loaded_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      s_in         = s_ff;
      prod_in      = PW'(cw[0] * ch[0]);
      sq_in        = (2*SW)'(ch[0] * ch[0]);
      pv_in        = 1'b0;
      acc_in       = pv_ff ? acc_ff + AW'(prod_ff) : acc_ff;
      en_in        = pv_ff ? en_ff + EW'(sq_ff[2*SW-2:0]) : en_ff;
      den_in       = den_ff;
      err_in       = err_ff;
      np_in        = np_ff;
      mue_in       = mue_ff;
      num_in       = num_ff;
      rv_in        = (rv_ff && rsp_tready) ? 1'b0 : rv_ff;
      rd_in        = rd_ff;
      ru_in        = ru_ff;
      case (state_ff)
         nlmsp_pkg::ST_IDLE: begin
            acc_in = '0;
            en_in  = '0;
            cnt_in = '0;
            if (req_tvalid) begin
               s_in         = req_tdata;
               phase_in     = 1'b0;
               err_in       = '0;
               np_in        = '0;
            end
         end
         nlmsp_pkg::ST_PRED: begin
            mode   = nlmsp_pkg::CELL_ROTATE;
            pv_in  = 1'b1;
            cnt_in = cnt_ff + CW'(1);
         end
         nlmsp_pkg::ST_EVAL: begin
            cnt_in = '0;
            if (phase_ff) begin
               np_in = pred_sat;
            end else begin
               err_in = EW_E'(s_ff) - EW_E'(pred_sat);
            end
         end
         nlmsp_pkg::ST_MU: begin
            mue_in = MW'(step_ff * err_mag);
            den_in = (en_ff == '0) ? EW'(1 << 30) : en_ff;
         end
         nlmsp_pkg::ST_TMUL: begin
            num_in = XW'(mue_ff * h_mag);
         end
         nlmsp_pkg::ST_TSTART: begin
            div_start = 1'b1;
         end
         nlmsp_pkg::ST_TWR: begin
            mode        = nlmsp_pkg::CELL_ROTATE;
            head_w_feed = w_new;
            cnt_in      = cnt_ff + CW'(1);
         end
         nlmsp_pkg::ST_SHIFT: begin
            mode      = nlmsp_pkg::CELL_SHIFT;
            loaded_in = loaded_next;
            acc_in    = '0;
            en_in     = '0;
            cnt_in    = '0;
            phase_in  = 1'b1;
         end
         nlmsp_pkg::ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = {7'b0, np_ff, err_ff};
               ru_in = (loaded_ff == CW'(ORDER));
            end
         end
         default: begin
            mode = nlmsp_pkg::CELL_HOLD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= nlmsp_pkg::ST_IDLE;
         step_ff   <= nlmsp_pkg::STEP_W'(nlmsp_pkg::STEP_RESET);
         loaded_ff <= '0;
         cnt_ff    <= '0;
         phase_ff  <= 1'b0;
         pv_ff     <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         loaded_ff <= loaded_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         pv_ff     <= pv_in;
         rv_ff     <= rv_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      prod_ff      <= prod_in;
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      en_ff        <= en_in;
      den_ff       <= den_in;
      err_ff       <= err_in;
      np_ff        <= np_in;
      mue_ff       <= mue_in;
      num_ff       <= num_in;
      rd_ff        <= rd_in;
      ru_ff        <= ru_in;
   end

   assign req_tready = (state_ff == nlmsp_pkg::ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = ru_ff;

endmodule

// ===== test/nlms_predictor_checker.sv =====
module nlms_predictor_checker #(
   parameter int ORDER = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [16:0] err;
      logic signed [15:0] next_pred;
      logic               ready;
   } nlms_result_type;

   // Shadow copy of the block's state.
   logic signed [31:0] weight [ORDER];
   logic signed [15:0] history [ORDER];
   int                 newest;
   int                 loaded;
   logic [15:0]        mu;
   nlms_result_type    expected_q[$];

   function automatic logic signed [15:0] predict_sample();
      longint acc;
      longint r;
      acc = 0;
      for (int i = 0; i < ORDER; i++)
         acc += longint'(weight[i]) * longint'(history[(newest + i) % ORDER]);
      // Round half up: an arithmetic shift is a floor.
      r = (acc + (64'sd1 <<< 23)) >>> 24;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic void adapt_weights(input int err);
      longint unsigned energy, emag, hmag, mag, q;
      longint h, delta, w;
      energy = 0;
      emag = (err < 0) ? -err : err;
      for (int i = 0; i < ORDER; i++) begin
         h = history[i];
         energy += h * h;
      end
      if (energy == 0) energy = 64'd1 << 30;
      for (int i = 0; i < ORDER; i++) begin
         h = history[(newest + i) % ORDER];
         hmag = (h < 0) ? -h : h;
         mag = (longint'(mu) * emag * hmag) << 10;
         q = (mag + energy / 2) / energy;
         delta = (((err < 0) != (h < 0)) ? -longint'(q) : longint'(q));
         w = longint'(weight[i]) + delta;
         if (w > 64'sh7FFF_FFFF) w = 64'sh7FFF_FFFF;
         if (w < -64'sh8000_0000) w = -64'sh8000_0000;
         weight[i] = 32'(w);
      end
   endfunction

   function automatic nlms_result_type step_sample(input logic signed [15:0] s);
      nlms_result_type res;
      int err;
      err = 0;
      res = '0;
      if (loaded >= ORDER) begin
         err = int'(s) - int'(predict_sample());
         adapt_weights(err);
      end
      newest = (newest + ORDER - 1) % ORDER;
      history[newest] = s;
      if (loaded < ORDER) loaded++;
      res.err = 17'(err);
      res.ready = (loaded >= ORDER);
      if (res.ready) res.next_pred = predict_sample();
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got,
               want);
      fail_count++;
   endtask

   // Watch both channels and the register port at each edge.
   always @(posedge clock) begin
      nlms_result_type want;
      nlms_result_type got;
      if (reset) begin
         for (int i = 0; i < ORDER; i++) begin
            weight[i] = nlmsp_pkg::init_weight(ORDER, i);
            history[i] = '0;
         end
         newest = ORDER - 1;
         loaded = 0;
         mu = nlmsp_pkg::STEP_RESET;
         expected_q.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_we) mu = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got.err = rsp_tdata[16:0];
            got.next_pred = rsp_tdata[32:17];
            got.ready = rsp_tuser;
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected transfer", 0, 0);
            end else begin
               want = expected_q.pop_front();
               if (got.err !== want.err) report_mismatch("error", got.err, want.err);
               if (got.next_pred !== want.next_pred)
                  report_mismatch("next_prediction", got.next_pred, want.next_pred);
               if (got.ready !== want.ready) report_mismatch("ready", got.ready, want.ready);
               if (rsp_tdata[39:33] !== '0) report_mismatch("pad bits", rsp_tdata[39:33], 0);
            end
            result_count++;
         end
         if (req_tvalid && req_tready)
            expected_q.push_back(step_sample(req_tdata));
      end
      pending_count = expected_q.size();
   end
endmodule

// ===== test/tb_nlms_adaptive_predictor.sv =====
module tb_nlms_adaptive_predictor;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ORDER = nlmsp_pkg::ORDER_DEF;
   localparam int SLOW_CYCLES = ORDER * 45 + 40;
   localparam longint CYCLE_LIMIT = 64'd2_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 0;
   logic [15:0] csr_wdata = '0;
   int          fail_count, pending_count, result_count;
   longint      cycle_count = 0;
   bit          quiet_phase = 0;
   bit          hold_long = 0;
   int          samples_sent = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   nlms_adaptive_predictor #(.ORDER(ORDER)) u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_we, .csr_wdata
   );

   nlms_predictor_checker #(.ORDER(ORDER)) u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_we, .csr_wdata,
      .fail_count, .pending_count, .result_count
   );

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: random stall bursts, none in the quiet phase, one long one on request.
   initial begin
      int n;
      bit long_done;
      long_done = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_long && !long_done) begin
            rsp_tready <= 0;
            for (int i = 0; i < 4000; i++) @(posedge clock);
            long_done = 1;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 11);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // One transfer on the input channel, sometimes after a random gap. The valid stays high
   // after the transfer so that the next sample can follow without a gap.
   task automatic send_sample(input logic [15:0] s);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SLOW_CYCLES) @(posedge clock);
   endtask

   task automatic write_step_size(input logic [15:0] v);
      drain_results();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Mostly a smooth waveform with random content, sometimes wild samples.
   function automatic logic [15:0] random_sample(input int k, input int amp, input int per);
      int v;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      v = (k % per < per / 2) ? (k % per) * amp / per : (per - k % per) * amp / per;
      v = v - amp / 4 + $urandom_range(0, 63) - 32;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
   endfunction

   initial begin
      logic [15:0] steps [5];
      int amp, per;
      steps = '{16'd0, 16'hFFFF, 16'd8192, 16'd1, 16'd300};
      repeat (10) @(posedge clock);
      reset <= 0;

      // Directed: zero energy first, then extremes.
      for (int i = 0; i < ORDER + 2; i++) send_sample(16'h0000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      for (int i = 0; i < 6; i++) send_sample(16'h7FFF);
      drain_results();

      // Random phases at several learning rates.
      for (int p = 0; p < 5; p++) begin
         write_step_size(steps[p]);
         amp = $urandom_range(100, 60000);
         per = $urandom_range(4, 40);
         if (p == 2) hold_long = 1;
         for (int k = 0; k < 80; k++) begin
            if (p == 4 && k == 40) quiet_phase = 1;
            send_sample(random_sample(k, amp, per));
         end
      end
      write_step_size(16'($urandom));
      for (int k = 0; k < 30; k++) send_sample(16'($urandom));
      drain_results();

      $display("%0d samples sent, %0d results checked over six learning rates",
               samples_sent, result_count);
      $display("including zero-energy history, full-scale samples and a long output stall");
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
